// ===== hdl/smpc_pkg.sv =====
// Package for the sliding mode position controller.
// Holds shared constants, register indexes, state and command types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package smpc_pkg;

    localparam int AVG_WINDOW_DEF = 10;
    localparam int FRAC           = 12;
    localparam int IN_TDATA_W     = 176;
    localparam int OUT_TDATA_W    = 64;
    localparam int CFG_ADDR_W     = 3;
    localparam int CFG_DATA_W     = 15;
    localparam int CMD_W          = 14;
    localparam int YAW_W          = 16;
    localparam int CMD_MAX        = 4096;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_SLOPE = 3'd0,
        CFG_GAIN  = 3'd1,
        CFG_DGAIN = 3'd2,
        CFG_RATE  = 3'd3,
        CFG_YAWG  = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [14:0] slope;
        logic [14:0] gain;
        logic [14:0] dgain;
        logic [9:0]  rate;
        logic [14:0] yawg;
    } t_cfg;

    typedef enum logic [3:0] {
        M_NONE, M_SX, M_SY, M_SZ, M_DG, M_GX, M_GY, M_GZ, M_YAW, M_AX, M_AY
    } t_msel;

    typedef enum logic [3:0] {
        U_NONE, U_SX, U_SY, U_SZ, U_DG, U_GX, U_GY, U_Z, U_YAW, U_AX, U_AY
    } t_usel;

    typedef enum logic [3:0] {
        ST_IDLE, ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6, ST_P7, ST_P8,
        ST_WAIT, ST_AX, ST_AY, ST_AC, ST_FIN
    } t_state;

    typedef struct packed {
        logic  load;
        t_msel msel;
        t_usel usel;
        logic  ring_upd;
        logic  div_start;
        logic  out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_dp_sts;

endpackage
`default_nettype wire

// ===== hdl/smpc_div.sv =====
// Two-lane serial divider, one quotient bit per cycle, truncating toward zero.
// Both lanes share one unsigned divisor. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module smpc_div #(
    parameter int NUM_W = 21,
    parameter int DEN_W = 4
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic signed [NUM_W-1:0] i_num_a,
    input  wire logic signed [NUM_W-1:0] i_num_b,
    input  wire logic        [DEN_W-1:0] i_den,
    output logic                         o_done,
    output logic signed [NUM_W-1:0]      o_quo_a,
    output logic signed [NUM_W-1:0]      o_quo_b
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic [NUM_W-1:0] r_q_a, r_q_b;
    logic [DEN_W:0]   r_rem_a, r_rem_b;
    logic [DEN_W-1:0] r_den;
    logic             r_neg_a, r_neg_b;
    logic [DEN_W:0]   w_try_a, w_try_b;
    logic             w_ge_a, w_ge_b;

    always_comb begin
        w_try_a = {r_rem_a[DEN_W-1:0], r_q_a[NUM_W-1]};
        w_try_b = {r_rem_b[DEN_W-1:0], r_q_b[NUM_W-1]};
        w_ge_a  = w_try_a >= {1'b0, r_den};
        w_ge_b  = w_try_b >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(NUM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q_a   <= i_num_a[NUM_W-1] ? NUM_W'(-i_num_a) : i_num_a;
            r_q_b   <= i_num_b[NUM_W-1] ? NUM_W'(-i_num_b) : i_num_b;
            r_neg_a <= i_num_a[NUM_W-1];
            r_neg_b <= i_num_b[NUM_W-1];
            r_rem_a <= '0;
            r_rem_b <= '0;
            r_den   <= i_den;
        end else if (r_busy) begin
            r_rem_a <= w_ge_a ? w_try_a - {1'b0, r_den} : w_try_a;
            r_rem_b <= w_ge_b ? w_try_b - {1'b0, r_den} : w_try_b;
            r_q_a   <= {r_q_a[NUM_W-2:0], w_ge_a};
            r_q_b   <= {r_q_b[NUM_W-2:0], w_ge_b};
        end
    end

    assign o_done  = !r_busy;
    assign o_quo_a = r_neg_a ? NUM_W'(-$signed(r_q_a)) : $signed(r_q_a);
    assign o_quo_b = r_neg_b ? NUM_W'(-$signed(r_q_b)) : $signed(r_q_b);

endmodule
`default_nettype wire

// ===== hdl/smpc_datapath.sv =====
// Datapath: shared multiplier, surfaces, delta ring, accumulators, result register.
// Depends on smpc_pkg and smpc_div.
`timescale 1ns / 1ps
`default_nettype none
module smpc_datapath import smpc_pkg::*; #(
    parameter int AVG_WINDOW = AVG_WINDOW_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cfg               i_cfg,
    input  wire t_dp_cmd            i_cmd,
    output t_dp_sts                 o_sts,
    input  wire logic signed [15:0] i_est_x,
    input  wire logic signed [15:0] i_est_y,
    input  wire logic signed [15:0] i_est_z,
    input  wire logic signed [15:0] i_vel_x,
    input  wire logic signed [15:0] i_vel_y,
    input  wire logic signed [15:0] i_vel_z,
    input  wire logic signed [14:0] i_est_yaw,
    input  wire logic signed [15:0] i_goal_x,
    input  wire logic signed [15:0] i_goal_y,
    input  wire logic signed [15:0] i_goal_z,
    input  wire logic signed [14:0] i_goal_yaw,
    input  wire logic               i_m_tready,
    output logic                    o_m_tvalid,
    output logic signed [CMD_W-1:0] o_cmd_x,
    output logic signed [CMD_W-1:0] o_cmd_y,
    output logic signed [CMD_W-1:0] o_cmd_z,
    output logic signed [YAW_W-1:0] o_cmd_yaw_rate
);
    localparam int DELTA_W = 17;
    localparam int SUM_W   = DELTA_W + $clog2(AVG_WINDOW);
    localparam int CNT_W   = $clog2(AVG_WINDOW + 1);
    localparam int POS_W   = $clog2(AVG_WINDOW);
    localparam int A_W     = 26;
    localparam int B_W     = (SUM_W > 22) ? SUM_W : 22;
    localparam int P_W     = A_W + B_W;
    localparam int ACC_W   = P_W + 1;

    logic signed [16:0]        r_ex, r_ey, r_ez;
    logic signed [15:0]        r_eyaw;
    logic signed [15:0]        r_vx, r_vy, r_vz;
    logic signed [15:0]        r_sx, r_sy;
    logic signed [B_W-1:0]     r_sz;
    logic [24:0]               r_dg;
    logic signed [P_W-1:0]     r_prod;
    logic signed [ACC_W-1:0]   r_acc_x, r_acc_y;
    logic signed [CMD_W-1:0]   r_oz;
    logic signed [YAW_W-1:0]   r_oyaw;
    logic signed [15:0]        r_prev_x, r_prev_y;
    logic signed [DELTA_W-1:0] r_ring_x [AVG_WINDOW];
    logic signed [DELTA_W-1:0] r_ring_y [AVG_WINDOW];
    logic signed [SUM_W-1:0]   r_sum_x, r_sum_y;
    logic [POS_W-1:0]          r_pos;
    logic [CNT_W-1:0]          r_fill;
    logic                      r_m_valid;
    logic signed [CMD_W-1:0]   r_out_x, r_out_y, r_out_z;
    logic signed [YAW_W-1:0]   r_out_yaw;

    logic signed [A_W-1:0]     w_a;
    logic signed [B_W-1:0]     w_b;
    logic signed [P_W-1:0]     w_sh;
    logic signed [15:0]        w_vsel;
    logic signed [ACC_W-1:0]   w_surf;
    logic signed [15:0]        w_surf16;
    logic signed [CMD_W-1:0]   w_z;
    logic signed [YAW_W-1:0]   w_yaw;
    logic signed [ACC_W-1:0]   w_xs, w_ys;
    logic signed [CMD_W-1:0]   w_cx, w_cy;
    logic signed [DELTA_W-1:0] w_dx, w_dy;
    logic                      w_div_done;
    logic signed [SUM_W-1:0]   w_avg_x, w_avg_y;

    always_comb begin
        w_a = '0;
        w_b = '0;
        case (i_cmd.msel)
            M_SX:    begin w_a = A_W'(i_cfg.slope); w_b = B_W'(r_ex); end
            M_SY:    begin w_a = A_W'(i_cfg.slope); w_b = B_W'(r_ey); end
            M_SZ:    begin w_a = A_W'(i_cfg.slope); w_b = B_W'(r_ez); end
            M_DG:    begin w_a = A_W'(i_cfg.dgain); w_b = B_W'(i_cfg.rate); end
            M_GX:    begin w_a = A_W'(i_cfg.gain);  w_b = B_W'(r_sx); end
            M_GY:    begin w_a = A_W'(i_cfg.gain);  w_b = B_W'(r_sy); end
            M_GZ:    begin w_a = A_W'(i_cfg.gain);  w_b = -r_sz; end
            M_YAW:   begin w_a = A_W'(i_cfg.yawg);  w_b = B_W'(r_eyaw); end
            M_AX:    begin w_a = A_W'(r_dg);        w_b = B_W'(w_avg_x); end
            M_AY:    begin w_a = A_W'(r_dg);        w_b = B_W'(w_avg_y); end
            default: begin w_a = '0;                w_b = '0; end
        endcase
    end

    always_comb begin
        w_sh = r_prod >>> FRAC;
        case (i_cmd.usel)
            U_SY:    w_vsel = r_vy;
            U_SZ:    w_vsel = r_vz;
            default: w_vsel = r_vx;
        endcase
        w_surf = ACC_W'(w_vsel) - ACC_W'(w_sh);
        if (w_surf > 32767) begin
            w_surf16 = 16'sh7FFF;
        end else if (w_surf < -32768) begin
            w_surf16 = 16'sh8000;
        end else begin
            w_surf16 = 16'(w_surf);
        end
        if (w_sh > CMD_MAX) begin
            w_z = CMD_W'(CMD_MAX);
        end else if (w_sh < -CMD_MAX) begin
            w_z = CMD_W'(-CMD_MAX);
        end else begin
            w_z = CMD_W'(w_sh);
        end
        if (w_sh > 32767) begin
            w_yaw = 16'sh7FFF;
        end else if (w_sh < -32768) begin
            w_yaw = 16'sh8000;
        end else begin
            w_yaw = 16'(w_sh);
        end
        w_xs = r_acc_x >>> FRAC;
        w_ys = r_acc_y >>> FRAC;
        if (w_xs > CMD_MAX) begin
            w_cx = CMD_W'(CMD_MAX);
        end else if (w_xs < -CMD_MAX) begin
            w_cx = CMD_W'(-CMD_MAX);
        end else begin
            w_cx = CMD_W'(w_xs);
        end
        if (w_ys > CMD_MAX) begin
            w_cy = CMD_W'(CMD_MAX);
        end else if (w_ys < -CMD_MAX) begin
            w_cy = CMD_W'(-CMD_MAX);
        end else begin
            w_cy = CMD_W'(w_ys);
        end
        w_dx = DELTA_W'(r_sx) - DELTA_W'(r_prev_x);
        w_dy = DELTA_W'(r_sy) - DELTA_W'(r_prev_y);
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_a * w_b;
        if (i_cmd.load) begin
            r_ex   <= 17'(i_goal_x) - 17'(i_est_x);
            r_ey   <= 17'(i_goal_y) - 17'(i_est_y);
            r_ez   <= 17'(i_goal_z) - 17'(i_est_z);
            r_eyaw <= 16'(i_goal_yaw) - 16'(i_est_yaw);
            r_vx   <= i_vel_x;
            r_vy   <= i_vel_y;
            r_vz   <= i_vel_z;
        end
        case (i_cmd.usel)
            U_SX:    r_sx <= w_surf16;
            U_SY:    r_sy <= w_surf16;
            U_SZ:    r_sz <= B_W'(w_surf);
            U_DG:    r_dg <= r_prod[24:0];
            U_GX:    r_acc_x <= -ACC_W'(r_prod);
            U_GY:    r_acc_y <= ACC_W'(r_prod);
            U_Z:     r_oz <= w_z;
            U_YAW:   r_oyaw <= w_yaw;
            U_AX:    r_acc_x <= r_acc_x + ACC_W'(r_prod);
            U_AY:    r_acc_y <= r_acc_y + ACC_W'(r_prod);
            default: ;
        endcase
        if (i_cmd.out_load) begin
            r_out_x   <= w_cx;
            r_out_y   <= w_cy;
            r_out_z   <= r_oz;
            r_out_yaw <= r_oyaw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_x <= '0;
            r_prev_y <= '0;
            r_sum_x  <= '0;
            r_sum_y  <= '0;
            r_pos    <= '0;
            r_fill   <= '0;
            for (int i = 0; i < AVG_WINDOW; i++) begin
                r_ring_x[i] <= '0;
                r_ring_y[i] <= '0;
            end
        end else if (i_cmd.ring_upd) begin
            r_prev_x <= r_sx;
            r_prev_y <= r_sy;
            r_sum_x  <= r_sum_x - SUM_W'(r_ring_x[r_pos]) + SUM_W'(w_dx);
            r_sum_y  <= r_sum_y - SUM_W'(r_ring_y[r_pos]) + SUM_W'(w_dy);
            r_ring_x[r_pos] <= w_dx;
            r_ring_y[r_pos] <= w_dy;
            r_pos <= (r_pos == POS_W'(AVG_WINDOW - 1)) ? '0 : r_pos + 1'b1;
            if (r_fill < CNT_W'(AVG_WINDOW)) begin
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    smpc_div #(
        .NUM_W (SUM_W),
        .DEN_W (CNT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num_a (r_sum_x),
        .i_num_b (r_sum_y),
        .i_den   (r_fill),
        .o_done  (w_div_done),
        .o_quo_a (w_avg_x),
        .o_quo_b (w_avg_y)
    );

    assign o_sts.div_done = w_div_done;
    assign o_sts.out_free = !r_m_valid || i_m_tready;
    assign o_m_tvalid     = r_m_valid;
    assign o_cmd_x        = r_out_x;
    assign o_cmd_y        = r_out_y;
    assign o_cmd_z        = r_out_z;
    assign o_cmd_yaw_rate = r_out_yaw;

endmodule
`default_nettype wire

// ===== hdl/smpc_ctrl.sv =====
// Controller: sequences the datapath through one item per pass.
// Depends on smpc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module smpc_ctrl import smpc_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_s_tvalid,
    output logic         o_s_tready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_cmd.load      = 1'b0;
        o_cmd.msel      = M_NONE;
        o_cmd.usel      = U_NONE;
        o_cmd.ring_upd  = 1'b0;
        o_cmd.div_start = 1'b0;
        o_cmd.out_load  = 1'b0;
        o_s_tready      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_P0;
                end
            end
            ST_P0: begin
                o_cmd.msel = M_SX;
                n_state    = ST_P1;
            end
            ST_P1: begin
                o_cmd.usel = U_SX;
                o_cmd.msel = M_SY;
                n_state    = ST_P2;
            end
            ST_P2: begin
                o_cmd.usel = U_SY;
                o_cmd.msel = M_SZ;
                n_state    = ST_P3;
            end
            ST_P3: begin
                o_cmd.usel     = U_SZ;
                o_cmd.msel     = M_DG;
                o_cmd.ring_upd = 1'b1;
                n_state        = ST_P4;
            end
            ST_P4: begin
                o_cmd.usel      = U_DG;
                o_cmd.msel      = M_GX;
                o_cmd.div_start = 1'b1;
                n_state         = ST_P5;
            end
            ST_P5: begin
                o_cmd.usel = U_GX;
                o_cmd.msel = M_GY;
                n_state    = ST_P6;
            end
            ST_P6: begin
                o_cmd.usel = U_GY;
                o_cmd.msel = M_GZ;
                n_state    = ST_P7;
            end
            ST_P7: begin
                o_cmd.usel = U_Z;
                o_cmd.msel = M_YAW;
                n_state    = ST_P8;
            end
            ST_P8: begin
                o_cmd.usel = U_YAW;
                n_state    = ST_WAIT;
            end
            ST_WAIT: begin
                if (i_sts.div_done) begin
                    n_state = ST_AX;
                end
            end
            ST_AX: begin
                o_cmd.msel = M_AX;
                n_state    = ST_AY;
            end
            ST_AY: begin
                o_cmd.usel = U_AX;
                o_cmd.msel = M_AY;
                n_state    = ST_AC;
            end
            ST_AC: begin
                o_cmd.usel = U_AY;
                n_state    = ST_FIN;
            end
            ST_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// ===== hdl/sliding_mode_position_controller.sv =====
// Sliding mode position controller top level: register file, stream unpacking,
// controller and datapath. Depends on smpc_pkg, smpc_ctrl and smpc_datapath.
//
// Usage: one control tick enters as an item on the s_ stream (positions,
// velocities, yaw, goals), and one command item leaves on the m_ stream
// (cmd_x, cmd_y, cmd_z, cmd_yaw_rate). Gains and the loop rate are written
// through the cfg channel, which is always ready; they are to be written only
// while the block is idle, which the block itself does not enforce.
// The result waits on the serial divider that averages the delta ring, one
// quotient bit per cycle over SUM_W bits, where SUM_W is 17 + clog2(AVG_WINDOW).
// The other work is ten products on one shared multiplier.
// A new item is taken only once the previous one has reached the result
// register, so one item is in work at a time.
// Reset clears the previous surfaces, the delta ring, its sum and fill count,
// and loads the default gains. When the receiver stalls, the result register
// holds; the next item is still accepted and worked, and waits at the end
// until the result register frees.
`timescale 1ns / 1ps
`default_nettype none
module sliding_mode_position_controller import smpc_pkg::*; #(
    parameter int AVG_WINDOW = AVG_WINDOW_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    // est_x, est_y, est_z, vel_x, vel_y, vel_z, est_yaw, goal_x, goal_y, goal_z, goal_yaw
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    // cmd_x, cmd_y, cmd_z, cmd_yaw_rate
    output logic [OUT_TDATA_W-1:0]      o_m_tdata,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);
    t_cfg    r_cfg;
    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic signed [CMD_W-1:0] w_cmd_x, w_cmd_y, w_cmd_z;
    logic signed [YAW_W-1:0] w_cmd_yaw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slope <= 15'd3277;
            r_cfg.gain  <= 15'd3277;
            r_cfg.dgain <= 15'd410;
            r_cfg.rate  <= 10'd50;
            r_cfg.yawg  <= 15'd2048;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                CFG_SLOPE: r_cfg.slope <= i_cfg_data;
                CFG_GAIN:  r_cfg.gain  <= i_cfg_data;
                CFG_DGAIN: r_cfg.dgain <= i_cfg_data;
                CFG_RATE:  r_cfg.rate  <= i_cfg_data[9:0];
                CFG_YAWG:  r_cfg.yawg  <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    smpc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    smpc_datapath #(
        .AVG_WINDOW (AVG_WINDOW)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_est_x        (i_s_tdata[15:0]),
        .i_est_y        (i_s_tdata[31:16]),
        .i_est_z        (i_s_tdata[47:32]),
        .i_vel_x        (i_s_tdata[63:48]),
        .i_vel_y        (i_s_tdata[79:64]),
        .i_vel_z        (i_s_tdata[95:80]),
        .i_est_yaw      (i_s_tdata[110:96]),
        .i_goal_x       (i_s_tdata[126:111]),
        .i_goal_y       (i_s_tdata[142:127]),
        .i_goal_z       (i_s_tdata[158:143]),
        .i_goal_yaw     (i_s_tdata[173:159]),
        .i_m_tready     (i_m_tready),
        .o_m_tvalid     (o_m_tvalid),
        .o_cmd_x        (w_cmd_x),
        .o_cmd_y        (w_cmd_y),
        .o_cmd_z        (w_cmd_z),
        .o_cmd_yaw_rate (w_cmd_yaw)
    );

    assign o_m_tdata = {6'd0, w_cmd_yaw, w_cmd_z, w_cmd_y, w_cmd_x};

endmodule
`default_nettype wire

// ===== tb/tb_sliding_mode_position_controller.sv =====
// Testbench for the sliding mode position controller: streams control ticks,
// predicts the four commands per tick and checks them field by field.
// Depends on smpc_pkg and the sliding_mode_position_controller RTL.
`timescale 1ns / 1ps
`default_nettype none
module tb_sliding_mode_position_controller;
    import smpc_pkg::*;

    typedef struct packed {
        logic signed [15:0] cyaw;
        logic signed [13:0] cz;
        logic signed [13:0] cy;
        logic signed [13:0] cx;
    } t_cmd;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_s_tvalid = 1'b0;
    logic [IN_TDATA_W-1:0] i_s_tdata = '0;
    logic i_m_tready = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic o_s_tready, o_m_tvalid, o_cfg_ready;
    logic [OUT_TDATA_W-1:0] o_m_tdata;

    sliding_mode_position_controller uut (.*);

    always #2 i_clk = ~i_clk;

    // predictor state
    longint slope_r, gain_r, dgain_r, rate_r, yawg_r;
    longint prev_sx, prev_sy, sum_x, sum_y;
    longint ring_x[10], ring_y[10];
    int ring_pos, fill_cnt;

    logic [IN_TDATA_W-1:0] pending_ticks[$];
    t_cmd expected_cmds[$];
    int errors = 0;
    bit calm = 1'b0;
    int send_gap = 0, recv_gap = 0;

    function automatic longint floor_q12(longint v);
        return v >>> 12;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic int fld_lsb(int k);
        return (k < 7) ? k * 16 : k * 16 - 1;
    endfunction

    function automatic int fld_w(int k);
        return (k == 6 || k == 10) ? 15 : 16;
    endfunction

    function automatic longint fld(logic [IN_TDATA_W-1:0] d, int k);
        logic [15:0] v;
        v = d[fld_lsb(k) +: 16];
        if (fld_w(k) == 15)
            return longint'($signed(v[14:0]));
        return longint'($signed(v));
    endfunction

    function automatic logic [IN_TDATA_W-1:0] put_fld(logic [IN_TDATA_W-1:0] d, int k,
                                                      logic [15:0] v);
        if (fld_w(k) == 15)
            d[fld_lsb(k) +: 15] = v[14:0];
        else
            d[fld_lsb(k) +: 16] = v;
        return d;
    endfunction

    function automatic t_cmd predict_cmd(logic [IN_TDATA_W-1:0] d);
        longint ex, ey, ez, eyaw, sx, sy, sz, dx, dy, ax, ay, dg;
        t_cmd r;
        ex = fld(d, 7) - fld(d, 0);
        ey = fld(d, 8) - fld(d, 1);
        ez = fld(d, 9) - fld(d, 2);
        eyaw = fld(d, 10) - fld(d, 6);
        sx = clip(fld(d, 3) - floor_q12(slope_r * ex), -32768, 32767);
        sy = clip(fld(d, 4) - floor_q12(slope_r * ey), -32768, 32767);
        sz = fld(d, 5) - floor_q12(slope_r * ez);
        dx = sx - prev_sx;
        dy = sy - prev_sy;
        prev_sx = sx;
        prev_sy = sy;
        sum_x = sum_x - ring_x[ring_pos] + dx;
        sum_y = sum_y - ring_y[ring_pos] + dy;
        ring_x[ring_pos] = dx;
        ring_y[ring_pos] = dy;
        ring_pos = (ring_pos + 1) % 10;
        if (fill_cnt < 10) fill_cnt++;
        ax = sum_x / fill_cnt;
        ay = sum_y / fill_cnt;
        dg = dgain_r * rate_r;
        r.cx = 14'(clip(floor_q12(dg * ax - gain_r * sx), -4096, 4096));
        r.cy = 14'(clip(floor_q12(dg * ay + gain_r * sy), -4096, 4096));
        r.cz = 14'(clip(floor_q12(-gain_r * sz), -4096, 4096));
        r.cyaw = 16'(clip(floor_q12(yawg_r * eyaw), -32768, 32767));
        return r;
    endfunction

    function automatic logic [14:0] rand_yaw();
        return 15'($urandom_range(0, 25736) - 12868);
    endfunction

    function automatic logic [IN_TDATA_W-1:0] rand_tick(bit wild);
        logic [IN_TDATA_W-1:0] d;
        logic [15:0] v;
        d = '0;
        for (int k = 0; k < 11; k++) begin
            if (fld_w(k) == 15) begin
                v = wild ? 16'($urandom) : {1'b0, rand_yaw()};
            end else begin
                v = 16'($urandom);
                if (!wild) v = 16'($signed(v) >>> $urandom_range(0, 4));
            end
            d = put_fld(d, k, v);
        end
        return d;
    endfunction

    function automatic logic [IN_TDATA_W-1:0] fill_tick(logic [15:0] v, logic [14:0] yaw);
        logic [IN_TDATA_W-1:0] d;
        d = '0;
        for (int k = 0; k < 11; k++)
            d = put_fld(d, k, (fld_w(k) == 15) ? {1'b0, yaw} : v);
        return d;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                expected_cmds.push_back(predict_cmd(i_s_tdata));
                void'(pending_ticks.pop_front());
            end
            if (i_s_tvalid && !o_s_tready) begin
                // hold the item until accepted
            end else if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                i_s_tvalid <= 1'b0;
            end else if (pending_ticks.size() > 0) begin
                if (!calm && $urandom_range(0, 9) == 0) begin
                    send_gap <= $urandom_range(0, 2);
                    i_s_tvalid <= 1'b0;
                end else begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata <= pending_ticks[0];
                end
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_cmd got, want;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                got = t_cmd'(o_m_tdata[57:0]);
                if (expected_cmds.size() == 0) begin
                    $display("%0t: unexpected command item %h", $time, o_m_tdata);
                    errors++;
                end else begin
                    want = expected_cmds.pop_front();
                    if (got.cx !== want.cx || got.cy !== want.cy || got.cz !== want.cz
                        || got.cyaw !== want.cyaw) begin
                        $display({"%0t: expected x=%0d y=%0d z=%0d yaw=%0d",
                                  " actual x=%0d y=%0d z=%0d yaw=%0d"},
                                 $time, want.cx, want.cy, want.cz, want.cyaw,
                                 got.cx, got.cy, got.cz, got.cyaw);
                        errors++;
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                i_m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                recv_gap <= $urandom_range(0, 2);
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    task automatic drain();
        while (pending_ticks.size() > 0 || expected_cmds.size() > 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, int value);
        i_cfg_valid <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= CFG_DATA_W'(value);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_SLOPE: slope_r = value & 32'h7fff;
            CFG_GAIN:  gain_r = value & 32'h7fff;
            CFG_DGAIN: dgain_r = value & 32'h7fff;
            CFG_RATE:  rate_r = value & 32'h3ff;
            CFG_YAWG:  yawg_r = value & 32'h7fff;
            default: ;
        endcase
    endtask

    task automatic set_gains(int s, int g, int dg, int r, int y);
        write_reg(CFG_SLOPE, s);
        write_reg(CFG_GAIN, g);
        write_reg(CFG_DGAIN, dg);
        write_reg(CFG_RATE, r);
        write_reg(CFG_YAWG, y);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        slope_r = 3277; gain_r = 3277; dgain_r = 410; rate_r = 50; yawg_r = 2048;
        prev_sx = 0; prev_sy = 0; sum_x = 0; sum_y = 0;
        ring_pos = 0; fill_cnt = 0;
        for (int k = 0; k < 10; k++) begin
            ring_x[k] = 0;
            ring_y[k] = 0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes at default gains
        pending_ticks.push_back(fill_tick(16'h0000, 15'h0000));
        pending_ticks.push_back(fill_tick(16'h7fff, 15'd12868));
        pending_ticks.push_back(fill_tick(16'h8000, -15'sd12868));
        pending_ticks.push_back(fill_tick(16'hffff, 15'h7fff));
        for (int k = 0; k < 11; k++) begin
            logic [IN_TDATA_W-1:0] d;
            d = '0;
            if (fld_w(k) == 15)
                d = put_fld(d, k, (k & 1) ? 16'h4000 : 16'h3fff);
            else
                d = put_fld(d, k, (k & 1) ? 16'h8000 : 16'h7fff);
            pending_ticks.push_back(d);
        end
        drain();

        // wait for results before sending more
        set_gains(32767, 32767, 32767, 1000, 32767);
        for (int k = 0; k < 6; k++) pending_ticks.push_back(rand_tick(1'b1));
        drain();
        set_gains(0, 0, 0, 0, 0);
        for (int k = 0; k < 4; k++) pending_ticks.push_back(rand_tick(1'b1));
        drain();
        set_gains(1, 1, 1, 1, 1);
        for (int k = 0; k < 4; k++) pending_ticks.push_back(rand_tick(1'b0));
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            set_gains($urandom_range(0, 32767) >> $urandom_range(0, 4),
                      $urandom_range(0, 32767) >> $urandom_range(0, 4),
                      $urandom_range(0, 32767) >> $urandom_range(0, 6),
                      $urandom_range(1, 1000), $urandom_range(0, 32767));
            if (ph == 5) calm = 1'b1;
            for (int k = 0; k < 300; k++)
                pending_ticks.push_back(rand_tick($urandom_range(0, 4) == 0));
            drain();
        end

        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #4000000;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
`default_nettype wire
